[sv/lcgbs_pkg.sv]
// Shared types and constants for the LCG with bit statistics block.
// No dependencies; used by all modules of the block.
package lcgbs_pkg;

  localparam int DATA_W          = 64;  // configuration write data width
  localparam int STEP_W          = 32;  // step count and step limit width
  localparam int CNT_OUT_W       = 32;  // counter read result width
  localparam int IDX_W           = 6;   // bit index field width
  localparam int WORD_WIDTH_DEF  = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_STEP    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_COMPLETE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_MULT   = 3'd0,
    CFG_INCR   = 3'd1,
    CFG_MOD    = 3'd2,
    CFG_SEED   = 3'd3,
    CFG_LIMIT  = 3'd4
  } cfg_idx_t;

  // commands from the sequencer to the bit counter file
  typedef struct packed {
    logic             clear;
    logic             sweep;
    logic             read;
    logic [IDX_W-1:0] idx;
  } cnt_cmd_t;

endpackage

[sv/lcgbs_datapath.sv]
// Iterative next-value unit: shift-add multiply, add, restoring modulo.
// One shared adder/subtractor serves all three phases. Uses lcgbs_pkg.
module lcgbs_datapath #(
  parameter int WORD_WIDTH = lcgbs_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] mult,
  input  logic [WORD_WIDTH-1:0] incr,
  input  logic [WORD_WIDTH-1:0] modulus,
  input  logic [WORD_WIDTH-1:0] x,
  output logic                  done,
  output logic                  over,
  output logic [WORD_WIDTH-1:0] nx
);

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W) + 1;

  typedef enum logic [1:0] {IDLE, MUL, ADD, DIV} state_t;

  state_t         state;
  logic [W-1:0]   hi, lo, b, q, rem;
  logic [CW-1:0]  cnt;

  // shared unit
  logic [W:0]     op_a, op_b;
  logic           cin;
  logic [W+1:0]   sum;
  logic [W:0]     t;
  logic           ge;

  assign t = {rem, q[W-1]};

  always_comb begin
    op_a = '0;
    op_b = '0;
    cin  = 1'b0;
    case (state)
      MUL: begin
        op_a = {1'b0, hi};
        op_b = b[0] ? {1'b0, mult} : '0;
      end
      ADD: begin
        op_a = {1'b0, lo};
        op_b = {1'b0, incr};
      end
      DIV: begin
        op_a = t;
        op_b = ~{1'b0, modulus};
        cin  = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, op_b} + {{(W+1){1'b0}}, cin};
  assign ge  = sum[W+1];
  assign nx  = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      over  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            hi    <= '0;
            lo    <= '0;
            b     <= x;
            cnt   <= '0;
            over  <= 1'b0;
            state <= MUL;
          end
        end
        MUL: begin
          hi  <= sum[W:1];
          lo  <= {sum[0], lo[W-1:1]};
          b   <= b >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            if (sum[W:1] != '0) begin
              over  <= 1'b1;
              done  <= 1'b1;
              state <= IDLE;
            end else begin
              state <= ADD;
            end
          end
        end
        ADD: begin
          q     <= sum[W-1:0];  // wraps modulo 2^W
          rem   <= '0;
          cnt   <= '0;
          state <= DIV;
        end
        DIV: begin
          rem <= ge ? sum[W-1:0] : t[W-1:0];
          q   <= q << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            done  <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[sv/lcgbs_counters.sv]
// Per-bit set counters held in a one-read, one-write memory with valid bits.
// Updates sweep one entry per cycle; read is registered. Uses lcgbs_pkg.
module lcgbs_counters #(
  parameter int WORD_WIDTH  = lcgbs_pkg::WORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = lcgbs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lcgbs_pkg::cnt_cmd_t              cmd,
  input  logic [WORD_WIDTH-1:0]            word,
  output logic                             done,
  output logic [lcgbs_pkg::CNT_OUT_W-1:0]  rd_count
);

  localparam int W  = WORD_WIDTH;
  localparam int C  = COUNT_WIDTH;
  localparam int AW = $clog2(W);

  logic [C-1:0]  mem [W];
  logic [W-1:0]  vld;
  logic [C-1:0]  rdata;
  logic [AW:0]   ptr;
  logic          sweeping, wr_pend, rd_pend, rd_zero;
  logic [AW-1:0] waddr, raddr;
  logic [C-1:0]  cur, inc;
  logic [63:0]   wide;

  assign raddr = sweeping ? ptr[AW-1:0] : cmd.idx[AW-1:0];
  assign cur   = vld[waddr] ? rdata : '0;
  assign inc   = (&cur) ? cur : cur + 1'b1;   // saturate
  assign wide  = 64'(vld[waddr] ? rdata : '0);

  always_ff @(posedge clk) begin
    if (sweeping || cmd.read) rdata <= mem[raddr];
    if (wr_pend && word[waddr]) mem[waddr] <= inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      sweeping <= 1'b0;
      wr_pend  <= 1'b0;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
      ptr      <= '0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      wr_pend <= 1'b0;
      if (cmd.clear) vld <= '0;
      if (cmd.sweep) begin
        sweeping <= 1'b1;
        ptr      <= '0;
      end else if (sweeping) begin
        waddr   <= ptr[AW-1:0];
        wr_pend <= 1'b1;
        ptr     <= ptr + 1'b1;
        if (ptr == (AW+1)'(W - 1)) sweeping <= 1'b0;
      end
      if (wr_pend) begin
        if (word[waddr]) vld[waddr] <= 1'b1;
        if (!sweeping) done <= 1'b1;
      end
      if (cmd.read) begin
        rd_pend <= 1'b1;
        waddr   <= cmd.idx[AW-1:0];
        rd_zero <= (32'(cmd.idx) >= 32'(W));
      end
      if (rd_pend) begin
        done     <= 1'b1;
        rd_count <= rd_zero ? '0 : wide[lcgbs_pkg::CNT_OUT_W-1:0];
      end
    end
  end

endmodule

[sv/lcg_with_bit_statistics_core.sv]
// Linear congruential generator with per-bit statistics: top-level sequencer.
// Instantiates lcgbs_datapath and lcgbs_counters; uses lcgbs_pkg.
//
// One item at a time. A step runs a shift-add multiply and a restoring
// modulo on one shared adder, then sweeps the bit positions to update the
// counter memory with one read and one write a cycle. Input stall is high
// while an item is in progress; a result waits in the output register until taken.
// Configuration writes are always ready and are only to be made while idle.
module lcg_with_bit_statistics_core #(
  parameter int WORD_WIDTH  = lcgbs_pkg::WORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = lcgbs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [lcgbs_pkg::DATA_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [lcgbs_pkg::IDX_W-1:0]       bit_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [WORD_WIDTH-1:0]             value,
  output logic [lcgbs_pkg::STEP_W-1:0]      step_number,
  output logic                              back_to_seed,
  output logic [1:0]                        status,
  output logic [lcgbs_pkg::CNT_OUT_W-1:0]   counter_value
);

  localparam int W = WORD_WIDTH;

  typedef enum logic [2:0] {IDLE, CALC, SWEEP, RDWAIT, RESP} state_t;

  state_t                         state;
  logic [W-1:0]                   mult, incr, modulus, seed, cur;
  logic [lcgbs_pkg::STEP_W-1:0]   limit, steps;
  logic                           halted;
  logic [W-1:0]                   r_value;
  logic [lcgbs_pkg::STEP_W-1:0]   r_num;
  logic                           r_back;
  lcgbs_pkg::status_t             r_status;
  logic [lcgbs_pkg::CNT_OUT_W-1:0] r_cnt;

  logic                           cfg_ok, accept;
  logic                           dp_start, dp_done, dp_over;
  logic [W-1:0]                   dp_nx;
  lcgbs_pkg::cnt_cmd_t            cmd;
  logic                           cn_done;
  logic [lcgbs_pkg::CNT_OUT_W-1:0] cn_count;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ok    = (limit != '0) && (mult < modulus) && (incr < modulus)
                     && (seed < modulus);

  always_comb begin
    dp_start  = 1'b0;
    cmd       = '0;
    cmd.idx   = bit_index;
    if (accept) begin
      case (lcgbs_pkg::opcode_t'(opcode))
        lcgbs_pkg::OP_STEP:
          dp_start = cfg_ok && !halted && (steps < limit);
        lcgbs_pkg::OP_READ:    cmd.read  = 1'b1;
        lcgbs_pkg::OP_RESTART: cmd.clear = 1'b1;
        default: ;
      endcase
    end
    if (state == CALC && dp_done && !dp_over) cmd.sweep = 1'b1;
  end

  lcgbs_datapath #(.WORD_WIDTH(W)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .start   (dp_start),
    .mult    (mult),
    .incr    (incr),
    .modulus (modulus),
    .x       (cur),
    .done    (dp_done),
    .over    (dp_over),
    .nx      (dp_nx)
  );

  lcgbs_counters #(.WORD_WIDTH(W), .COUNT_WIDTH(COUNT_WIDTH)) u_cnt (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .word     (cur),
    .done     (cn_done),
    .rd_count (cn_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mult      <= '0;
      incr      <= '0;
      modulus   <= '0;
      seed      <= '0;
      limit     <= '0;
      cur       <= '0;
      steps     <= '0;
      halted    <= 1'b0;
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (lcgbs_pkg::cfg_idx_t'(cfg_index))
          lcgbs_pkg::CFG_MULT:  mult    <= cfg_data[W-1:0];
          lcgbs_pkg::CFG_INCR:  incr    <= cfg_data[W-1:0];
          lcgbs_pkg::CFG_MOD:   modulus <= cfg_data[W-1:0];
          lcgbs_pkg::CFG_SEED:  seed    <= cfg_data[W-1:0];
          lcgbs_pkg::CFG_LIMIT: limit   <= cfg_data[lcgbs_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            r_value  <= '0;
            r_num    <= '0;
            r_back   <= 1'b0;
            r_status <= lcgbs_pkg::ST_OK;
            r_cnt    <= '0;
            state    <= RESP;
            case (lcgbs_pkg::opcode_t'(opcode))
              lcgbs_pkg::OP_STEP: begin
                r_num <= steps;
                if (!cfg_ok)             r_status <= lcgbs_pkg::ST_INVALID;
                else if (halted)         r_status <= lcgbs_pkg::ST_OVERFLOW;
                else if (steps >= limit) r_status <= lcgbs_pkg::ST_COMPLETE;
                else                     state    <= CALC;
              end
              lcgbs_pkg::OP_READ: state <= RDWAIT;
              lcgbs_pkg::OP_RESTART: begin
                cur    <= seed;
                steps  <= '0;
                halted <= 1'b0;
                r_status <= cfg_ok ? lcgbs_pkg::ST_OK : lcgbs_pkg::ST_INVALID;
              end
              default: ;
            endcase
          end
        end
        CALC: begin
          if (dp_done) begin
            if (dp_over) begin
              halted   <= 1'b1;
              r_status <= lcgbs_pkg::ST_OVERFLOW;
              state    <= RESP;
            end else begin
              cur     <= dp_nx;
              steps   <= steps + 1'b1;
              r_value <= dp_nx;
              r_back  <= (dp_nx == seed);
              state   <= SWEEP;
            end
          end
        end
        SWEEP:  if (cn_done) state <= RESP;
        RDWAIT: begin
          if (cn_done) begin
            r_cnt <= cn_count;
            state <= RESP;
          end
        end
        RESP: begin
          if (!out_valid || !out_stall) begin
            value         <= r_value;
            step_number   <= r_num;
            back_to_seed  <= r_back;
            status        <= r_status;
            counter_value <= r_cnt;
            out_valid     <= 1'b1;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
